@@ sv/sai_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab item allocator package
// Shared widths, sizes and codes of the slab item allocator.
// ----------------------------------------------------------------------------
package sai_pkg;

  localparam int unsigned NUM_SLABS    = 64;
  localparam int unsigned SLAB_BYTES   = 8192;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned FREE_DEPTH   = 1024;

  localparam int unsigned ADDR_W    = 19;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OFF_W     = $clog2(SLAB_BYTES);
  localparam int unsigned SLAB_W    = $clog2(NUM_SLABS);
  localparam int unsigned USED_W    = $clog2(NUM_SLABS + 1);
  localparam int unsigned PTR_W     = $clog2(FREE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(FREE_DEPTH + 1);
  localparam int unsigned DIV_CNT_W = $clog2(SIZE_W);

  localparam int unsigned USABLE_BYTES  = SLAB_BYTES - HEADER_BYTES;
  localparam int unsigned ITEM_SIZE_RST = 64;
  localparam int unsigned MIN_ITEM      = 16;
  localparam int unsigned RESET_EDGE    = (USABLE_BYTES / ITEM_SIZE_RST) * ITEM_SIZE_RST;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOM  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

endpackage

@@ sv/sai_req_if.sv @@
// ----------------------------------------------------------------------------
// Slab item allocator request channel
// Valid/ready channel that carries one allocate or free request per word.
// ----------------------------------------------------------------------------
interface sai_req_if;
  import sai_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, output func, output free_addr, input ready);
  modport sink   (input valid, input func, input free_addr, output ready);

endinterface

@@ sv/sai_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Slab item allocator response channel
// Valid/ready channel that carries one allocation result per word.
// ----------------------------------------------------------------------------
interface sai_rsp_if;
  import sai_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   item_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output item_addr, output status, input ready);
  modport sink   (input valid, input item_addr, input status, output ready);

endinterface

@@ sv/slab_item_allocator.sv @@
// ----------------------------------------------------------------------------
// Slab item allocator
// Fixed-size item allocator for one size class with a FIFO of freed items.
// ----------------------------------------------------------------------------
// Requests arrive on req_i, one word per request: allocate, or free the
// address given. Every request yields exactly one word on rsp_o, in order,
// with the allocated address (zero on free or failure) and a status.
// The response word passes the request register and then the response
// register after its request is accepted, and is held there until taken.
// While the divider is idle, one request can be accepted every cycle;
// the request register and the response register decouple the channels,
// so a request is still taken while one response waits. A full pipeline
// stalls the request side. The item size is written through cfg_we_i and
// cfg_wdata_i. After each write a serial divider computes the slab edge
// one quotient bit per cycle and holds req_i.ready low until it is done.
// Reset empties the free list, returns all slabs to the pool and sets the
// item size to 64 bytes with its edge ready, so requests are taken at once.
// The free list storage itself is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module slab_item_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sai_pkg::SIZE_W-1:0]  cfg_wdata_i,
  sai_req_if.sink                     req_i,
  sai_rsp_if.source                   rsp_o
);
  import sai_pkg::*;

  localparam logic [SIZE_W-1:0] UsableVec = SIZE_W'(USABLE_BYTES);

  logic [SIZE_W-1:0]    item_size_q, item_size_d;
  logic [SIZE_W-1:0]    eff_size;
  logic                 div_busy_q, div_busy_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [SIZE_W-1:0]    div_rem_q, div_rem_d;
  logic [SIZE_W:0]      div_shift;
  logic [SIZE_W-1:0]    div_rem_next;
  logic [SIZE_W-1:0]    edge_q, edge_d;

  logic [ADDR_W-1:0]    fifo_mem [FREE_DEPTH];
  logic [ADDR_W-1:0]    rdata_q;
  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic [SLAB_W-1:0]    cur_slab_q, cur_slab_d;
  logic [OFF_W-1:0]     offset_q, offset_d;
  logic                 partial_q, partial_d;
  logic [USED_W-1:0]    used_q, used_d;

  logic                 a_valid_q, a_valid_d;
  logic                 a_pop_q;
  logic [ADDR_W-1:0]    a_addr_q;
  status_e              a_status_q;
  logic                 o_valid_q, o_valid_d;
  logic [ADDR_W-1:0]    o_addr_q;
  status_e              o_status_q;

  logic                 req_fire, a_adv;
  logic                 is_free, fifo_full, do_push, do_pop, do_bump, oom;
  logic [SLAB_W-1:0]    slab_sel;
  logic [OFF_W-1:0]     off_sel;
  logic [OFF_W:0]       off_sum;
  logic [ADDR_W-1:0]    bump_addr, a_addr_d;
  status_e              a_status_d;

  assign eff_size = (item_size_q < SIZE_W'(MIN_ITEM)) ? SIZE_W'(MIN_ITEM) : item_size_q;

  // Restoring division of the usable bytes by the item size; only the
  // remainder is kept, since the edge is the usable bytes minus it.
  assign div_shift    = {div_rem_q, UsableVec[div_cnt_q]};
  assign div_rem_next = (div_shift >= {1'b0, eff_size}) ?
                        SIZE_W'(div_shift - {1'b0, eff_size}) : div_shift[SIZE_W-1:0];

  always_comb begin
    item_size_d = item_size_q;
    div_busy_d  = div_busy_q;
    div_cnt_d   = div_cnt_q;
    div_rem_d   = div_rem_q;
    edge_d      = edge_q;
    if (cfg_we_i) begin
      item_size_d = cfg_wdata_i;
      div_busy_d  = 1'b1;
      div_cnt_d   = DIV_CNT_W'(SIZE_W - 1);
      div_rem_d   = '0;
    end else if (div_busy_q) begin
      div_rem_d = div_rem_next;
      div_cnt_d = div_cnt_q - 1'b1;
      if (div_cnt_q == '0) begin
        div_busy_d = 1'b0;
        edge_d     = UsableVec - div_rem_next;
      end
    end
  end

  assign a_adv       = a_valid_q && (!o_valid_q || rsp_o.ready);
  assign req_i.ready = !div_busy_q && (!a_valid_q || a_adv);
  assign req_fire    = req_i.valid && req_i.ready;

  assign is_free   = (req_i.func == FuncFree);
  assign fifo_full = (count_q >= CNT_W'(FREE_DEPTH));
  assign do_push   = req_fire && is_free && !fifo_full;
  assign do_pop    = req_fire && !is_free && (count_q != '0);
  assign do_bump   = !is_free && (count_q == '0);
  assign oom       = do_bump && !partial_q && (used_q >= USED_W'(NUM_SLABS));
  assign slab_sel  = partial_q ? cur_slab_q : used_q[SLAB_W-1:0];
  assign off_sel   = partial_q ? offset_q : '0;
  assign off_sum   = {1'b0, off_sel} + {1'b0, eff_size};
  assign bump_addr = ADDR_W'({slab_sel, off_sel});

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    cur_slab_d = cur_slab_q;
    offset_d   = offset_q;
    partial_d  = partial_q;
    used_d     = used_q;
    a_addr_d   = '0;
    a_status_d = STATUS_OK;
    if (do_push) begin
      tail_d  = tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (do_pop) begin
      head_d  = head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (is_free && fifo_full) begin
      a_status_d = STATUS_FULL;
    end else if (oom) begin
      a_status_d = STATUS_OOM;
    end else if (do_bump) begin
      a_addr_d = bump_addr;
      if (req_fire) begin
        cur_slab_d = slab_sel;
        offset_d   = off_sum[OFF_W-1:0];
        partial_d  = (off_sum < {1'b0, edge_q});
        if (!partial_q) begin
          used_d = used_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (req_fire) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (a_adv) begin
      o_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_size_q <= SIZE_W'(ITEM_SIZE_RST);
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      div_rem_q   <= '0;
      edge_q      <= SIZE_W'(RESET_EDGE);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cur_slab_q  <= '0;
      offset_q    <= '0;
      partial_q   <= 1'b0;
      used_q      <= '0;
      a_valid_q   <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      item_size_q <= item_size_d;
      div_busy_q  <= div_busy_d;
      div_cnt_q   <= div_cnt_d;
      div_rem_q   <= div_rem_d;
      edge_q      <= edge_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cur_slab_q  <= cur_slab_d;
      offset_q    <= offset_d;
      partial_q   <= partial_d;
      used_q      <= used_d;
      a_valid_q   <= a_valid_d;
      o_valid_q   <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_mem[tail_q] <= req_i.free_addr;
    end
    if (do_pop) begin
      rdata_q <= fifo_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      a_pop_q    <= !is_free && (count_q != '0);
      a_addr_q   <= a_addr_d;
      a_status_q <= a_status_d;
    end
    if (a_adv) begin
      o_addr_q   <= a_pop_q ? rdata_q : a_addr_q;
      o_status_q <= a_status_q;
    end
  end

  assign rsp_o.valid     = o_valid_q;
  assign rsp_o.item_addr = o_addr_q;
  assign rsp_o.status    = o_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FREE_DEPTH))
    else $error("free list count exceeds its depth");

  a_count_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_W'(tail_q - head_q) == count_q[PTR_W-1:0])
    else $error("free list pointers disagree with the count");

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(NUM_SLABS))
    else $error("more slabs used than the pool holds");

  a_partial_slab : assert property (@(posedge clk_i) disable iff (!rst_ni)
    partial_q |-> (used_q != '0) && (USED_W'(cur_slab_q) == used_q - 1'b1))
    else $error("partial slab is not the most recently taken slab");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && (o_status_q != STATUS_OK) |-> (o_addr_q == '0))
    else $error("failed request returned a nonzero address");

endmodule
